// File: sv/flr_pkg.sv
// shared constants and types for the fixed-point line rasteriser
`default_nettype none
package flr_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int COLOR_BITS = 16;
   localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 2;
   localparam int INC_BITS   = FRAC_BITS + 2;
   localparam int DIV_BITS   = COORD_BITS + FRAC_BITS;
   localparam int DCNT_BITS  = $clog2(DIV_BITS + 1);

   // request modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   // controller to datapath
   typedef struct packed {
      logic load_line;   // latch endpoints and start the divider
      logic latch_inc;   // take the quotient as the minor increment
      logic emit_pixel;  // write the current pixel out and advance
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;    // output register can take a pixel this cycle
      logic div_done;    // divider finished
      logic last_pixel;  // major position has reached the end
   } status_type;

endpackage
`default_nettype wire

// File: sv/flr_if.sv
// request and pixel channel interfaces of the line rasteriser
`default_nettype none
interface flr_req_if;
   logic                  valid;
   logic                  ready;
   logic                  mode;
   flr_pkg::coord_type    start_x;
   flr_pkg::coord_type    start_y;
   flr_pkg::coord_type    end_x;
   flr_pkg::coord_type    end_y;
   flr_pkg::color_type    color_in;

   modport source (output valid, mode, start_x, start_y, end_x, end_y, color_in,
                   input ready);
   modport sink   (input valid, mode, start_x, start_y, end_x, end_y, color_in,
                   output ready);
endinterface

interface flr_rsp_if;
   logic                  valid;
   logic                  ready;
   flr_pkg::coord_type    pixel_x;
   flr_pkg::coord_type    pixel_y;
   flr_pkg::color_type    pixel_color;
   logic                  last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface
`default_nettype wire

// File: sv/flr_divider.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module flr_divider (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            load,
   input  wire logic [flr_pkg::DIV_BITS-1:0]    dividend,
   input  wire logic [flr_pkg::COORD_BITS-1:0]  divisor,
   output logic                                 done,
   output logic [flr_pkg::DIV_BITS-1:0]         quotient
);

   logic [flr_pkg::DIV_BITS-1:0]   quo_ff, quo_in;
   logic [flr_pkg::COORD_BITS-1:0] rem_ff, rem_in;
   logic [flr_pkg::COORD_BITS-1:0] dvs_ff, dvs_in;
   logic [flr_pkg::DCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [flr_pkg::COORD_BITS:0]   trial;
   logic [flr_pkg::COORD_BITS:0]   diff;
   logic                           fits;

   assign done     = (cnt_ff == flr_pkg::DCNT_BITS'(flr_pkg::DIV_BITS));
   assign quotient = quo_ff;

   always_comb begin
      trial  = {rem_ff, quo_ff[flr_pkg::DIV_BITS-1]};
      fits   = trial >= {1'b0, dvs_ff};
      diff   = trial - {1'b0, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (load) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
      end else if (!done) begin
         // remainder stays below the divisor so it fits back in coord width
         rem_in = fits ? diff[flr_pkg::COORD_BITS-1:0] : trial[flr_pkg::COORD_BITS-1:0];
         quo_in = {quo_ff[flr_pkg::DIV_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= flr_pkg::DCNT_BITS'(flr_pkg::DIV_BITS);
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule
`default_nettype wire

// File: sv/flr_datapath.sv
// line set-up, minor-axis accumulator and pixel output register
`default_nettype none
module flr_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire flr_pkg::cmd_type     cmd,
   output flr_pkg::status_type       status,
   input  wire flr_pkg::coord_type   start_x,
   input  wire flr_pkg::coord_type   start_y,
   input  wire flr_pkg::coord_type   end_x,
   input  wire flr_pkg::coord_type   end_y,
   input  wire flr_pkg::color_type   color_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output flr_pkg::coord_type        pixel_x,
   output flr_pkg::coord_type        pixel_y,
   output flr_pkg::color_type        pixel_color,
   output logic                      last
);

   // line state
   logic                           y_major_ff;
   logic                           count_up_ff;
   logic                           min_neg_ff;
   logic                           maj_zero_ff;
   flr_pkg::coord_type             maj_pos_ff, maj_pos_in;
   flr_pkg::coord_type             maj_fin_ff;
   logic [flr_pkg::ACC_BITS-1:0]   acc_ff, acc_in;
   logic [flr_pkg::INC_BITS-1:0]   inc_ff;
   flr_pkg::color_type             color_ff;

   // output register
   logic                           out_valid_ff, out_valid_in;
   flr_pkg::coord_type             out_x_ff, out_y_ff;
   flr_pkg::color_type             out_color_ff;
   logic                           out_last_ff;

   // set-up
   flr_pkg::coord_type             adx, ady, maj_len, min_len, maj_start, maj_end, min_start;
   logic                           y_major, min_neg, maj_up;
   logic [flr_pkg::DIV_BITS-1:0]   dividend;
   logic [flr_pkg::DIV_BITS-1:0]   quotient;
   logic                           div_done;
   logic [flr_pkg::INC_BITS-1:0]   mag;
   logic [flr_pkg::INC_BITS-1:0]   inc_in;
   logic [flr_pkg::ACC_BITS-1:0]   acc_seed;
   flr_pkg::coord_type             minor;
   logic                           fin;

   always_comb begin
      adx     = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
      ady     = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
      y_major = ady > adx;
      if (y_major) begin
         maj_len   = ady;
         min_len   = adx;
         min_neg   = end_x < start_x;
         maj_up    = end_y > start_y;
         maj_start = start_y;
         maj_end   = end_y;
         min_start = start_x;
      end else begin
         maj_len   = adx;
         min_len   = ady;
         min_neg   = end_y < start_y;
         maj_up    = end_x > start_x;
         maj_start = start_x;
         maj_end   = end_x;
         min_start = start_y;
      end
      dividend = {min_len, {flr_pkg::FRAC_BITS{1'b0}}};
      acc_seed = {2'b00, min_start, 1'b1, {(flr_pkg::FRAC_BITS-1){1'b0}}};
   end

   flr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (cmd.load_line),
      .dividend (dividend),
      .divisor  (maj_len),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      // quotient never exceeds one whole unit, so the low bits hold it all
      mag    = maj_zero_ff ? '0 : quotient[flr_pkg::INC_BITS-1:0];
      inc_in = min_neg_ff ? (~mag + 1'b1) : mag;
   end

   assign minor = acc_ff[flr_pkg::FRAC_BITS +: flr_pkg::COORD_BITS];
   assign fin   = (maj_pos_ff == maj_fin_ff);

   always_comb begin
      maj_pos_in = maj_pos_ff;
      acc_in     = acc_ff;
      if (cmd.load_line) begin
         maj_pos_in = maj_start;
         acc_in     = acc_seed;
      end else if (cmd.emit_pixel && !fin) begin
         maj_pos_in = count_up_ff ? maj_pos_ff + 1'b1 : maj_pos_ff - 1'b1;
         acc_in     = acc_ff + {{(flr_pkg::ACC_BITS-flr_pkg::INC_BITS)
                                 {inc_ff[flr_pkg::INC_BITS-1]}}, inc_ff};
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit_pixel) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      maj_pos_ff <= maj_pos_in;
      acc_ff     <= acc_in;
      if (cmd.load_line) begin
         y_major_ff  <= y_major;
         count_up_ff <= maj_up;
         min_neg_ff  <= min_neg;
         maj_zero_ff <= (maj_len == '0);
         maj_fin_ff  <= maj_end;
         color_ff    <= color_in;
      end
      if (cmd.latch_inc) begin
         inc_ff <= inc_in;
      end
      if (cmd.emit_pixel) begin
         out_x_ff     <= y_major_ff ? minor : maj_pos_ff;
         out_y_ff     <= y_major_ff ? maj_pos_ff : minor;
         out_color_ff <= color_ff;
         out_last_ff  <= fin;
      end
   end

   assign status.out_free   = !out_valid_ff || rsp_ready;
   assign status.div_done   = div_done;
   assign status.last_pixel = fin;

   assign rsp_valid   = out_valid_ff;
   assign pixel_x     = out_x_ff;
   assign pixel_y     = out_y_ff;
   assign pixel_color = out_color_ff;
   assign last        = out_last_ff;

endmodule
`default_nettype wire

// File: sv/flr_ctrl.sv
// controller state machine: idle, set-up division, pixel stepping
`default_nettype none
module flr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_mode,
   output logic                       req_ready,
   input  wire flr_pkg::status_type   status,
   output flr_pkg::cmd_type           cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_LINE   = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff != ST_DIVIDE) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            // a step with no line active is swallowed
            if (accept && req_mode == flr_pkg::MODE_START) begin
               cmd.load_line = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.latch_inc = 1'b1;
               state_in      = ST_LINE;
            end
         end
         ST_LINE: begin
            if (accept) begin
               if (req_mode == flr_pkg::MODE_START) begin
                  cmd.load_line = 1'b1;
                  state_in      = ST_DIVIDE;
               end else begin
                  cmd.emit_pixel = 1'b1;
                  if (status.last_pixel) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/fixed_point_line_rasterizer_unit.sv
// top level of the fixed-point line rasteriser
// usage:
//  - req_if carries requests; mode start latches both endpoints and a colour and
//    produces no pixel, mode step asks for the next pixel of the active line
//  - rsp_if carries pixels (x, y, colour, last); last marks the line's end point
//  - a start sets up the line with a restoring divider, one quotient bit per
//    cycle; req_if.ready is low while the division runs after a start is taken
//  - while a line is active and the output register is free, a step request is
//    taken every cycle; its pixel appears in the output register in the next cycle
//  - a line gives |major span| + 1 pixels; a step with no line active is taken
//    and dropped, a start during a line abandons it
//  - a pixel waiting in the output register does not stop the next request from
//    being taken as long as rsp_if.ready is high in the same cycle; when the
//    receiver stalls, req_if.ready drops until the pixel is taken
//  - synchronous reset clears the controller and the output valid; no line is
//    active afterwards
`default_nettype none
module fixed_point_line_rasterizer_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   flr_req_if.sink      req_if,
   flr_rsp_if.source    rsp_if
);

   flr_pkg::cmd_type    cmd;
   flr_pkg::status_type status;

   // sequencing: idle, divider set-up, stepping
   flr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.mode),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // endpoint set-up, accumulator and pixel register
   flr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .start_x     (req_if.start_x),
      .start_y     (req_if.start_y),
      .end_x       (req_if.end_x),
      .end_y       (req_if.end_y),
      .color_in    (req_if.color_in),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .pixel_x     (rsp_if.pixel_x),
      .pixel_y     (rsp_if.pixel_y),
      .pixel_color (rsp_if.pixel_color),
      .last        (rsp_if.last)
   );

endmodule
`default_nettype wire
